/* rtl/dstq_pkg.sv */
// Shared constants, codes and index helpers for the deadline-sorted timer queue.
`timescale 1ns / 1ps
package dstq_pkg;

	localparam int SLOTS  = 16;
	localparam int SLOT_W = $clog2(SLOTS);
	localparam int CNT_W  = $clog2(SLOTS + 1);
	localparam int OAW    = $clog2(2 * SLOTS);

	localparam logic [31:0] IDLE_INTERVAL_RST = 32'd60000;

	// command codes
	localparam logic [2:0] CMD_ADD    = 3'd0;
	localparam logic [2:0] CMD_UPDATE = 3'd1;
	localparam logic [2:0] CMD_CANCEL = 3'd2;
	localparam logic [2:0] CMD_TICK   = 3'd3;
	localparam logic [2:0] CMD_QUERY  = 3'd4;

	// result kinds
	localparam logic [2:0] KIND_HANDLE  = 3'd0;
	localparam logic [2:0] KIND_FIRED   = 3'd1;
	localparam logic [2:0] KIND_PENDING = 3'd2;
	localparam logic [2:0] KIND_NEXT    = 3'd3;
	localparam logic [2:0] KIND_FULL    = 3'd4;

	// slot status codes
	localparam logic [1:0] ST_FREE   = 2'd0;
	localparam logic [1:0] ST_IDLE   = 2'd1;
	localparam logic [1:0] ST_QUEUED = 2'd2;

	typedef logic [SLOT_W-1:0] slot_idx_t;
	typedef logic [CNT_W-1:0]  slot_cnt_t;
	typedef logic [OAW-1:0]    ord_addr_t;

	// position p past the ring head, wrapped into the slot range
	function automatic slot_idx_t ring_pos(input slot_idx_t head, input slot_cnt_t p);
		logic [SLOT_W:0] sum;
		sum = (SLOT_W + 1)'(head) + (SLOT_W + 1)'(p);
		if (sum >= (SLOT_W + 1)'(SLOTS))
			sum = sum - (SLOT_W + 1)'(SLOTS);
		return slot_idx_t'(sum);
	endfunction

	// order memory address: two banks of SLOTS entries
	function automatic ord_addr_t ord_addr(input logic bank, input slot_idx_t idx);
		ord_addr_t base;
		base = bank ? OAW'(SLOTS) : '0;
		return base + OAW'(idx);
	endfunction

endpackage

/* rtl/deadline_sorted_timer_queue_unit.sv */
// Top level of the deadline-sorted one-shot timer queue.
`timescale 1ns / 1ps
// Usage:
//   A request (command, slot, delay_ms, autorelease, now_ms) is taken at a
//   clock edge with start high and busy low; busy stays high until the request
//   is done. Each result sits on kind/handle/has_handle/value/last for one
//   cycle, marked by result_valid; last flags the final result of a request.
//   The first result comes at the earliest from the setup state through the
//   result register. The receiver cannot stall, so results are never held.
//   idle_interval is written through idle_interval_we/idle_interval_wdata;
//   the user must write it only while busy is low, as the block has no guard.
//   Query of an unqueued slot, cancel of an unqueued slot, add on a full
//   table and unknown commands finish straight from setup; query of a queued
//   slot reads the timer memory once. Add, update and cancel of a queued slot
//   walk the order memory (one entry a cycle, two read stages: order memory
//   then timer memory) to rebuild the order list. Tick steps through the fired
//   timers and the head timer with dependent order-then-timer memory reads.
//   The order list lives in two banks of a ring memory; each rebuild writes
//   the other bank. Timer start/delay pairs sit in a second memory.
//   Reset empties the queue, frees every slot and loads idle_interval with
//   60000; no clearing pass is needed.
module deadline_sorted_timer_queue_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [2:0]  command,
	input  logic [3:0]  slot,
	input  logic [31:0] delay_ms,
	input  logic        autorelease,
	input  logic [31:0] now_ms,
	input  logic        idle_interval_we,
	input  logic [31:0] idle_interval_wdata,
	output logic        result_valid,
	output logic [2:0]  kind,
	output logic [3:0]  handle,
	output logic        has_handle,
	output logic [31:0] value,
	output logic        last
);
	import dstq_pkg::*;

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_SETUP = 4'd1;
	localparam logic [3:0] S_PRUN  = 4'd2;
	localparam logic [3:0] S_PFIN  = 4'd3;
	localparam logic [3:0] S_TRD   = 4'd4;
	localparam logic [3:0] S_TTM   = 4'd5;
	localparam logic [3:0] S_TEV   = 4'd6;
	localparam logic [3:0] S_QEV   = 4'd7;

	logic [3:0]  state_q;
	logic [31:0] idle_q;
	logic [2:0]  cmd_q;
	logic [3:0]  slot_q;
	logic [31:0] ival_q;
	logic        ar_in_q;
	logic [31:0] now_q;

	logic [1:0]  status_q [SLOTS];
	logic        autorel_q [SLOTS];
	slot_cnt_t   cnt_q;
	slot_idx_t   head_q;
	logic        bank_q;

	// rebuild walk
	slot_cnt_t   r_q;
	slot_cnt_t   w_q;
	logic        v_s1;
	logic        v_s2;
	slot_idx_t   e_s2;
	slot_idx_t   tgt_q;
	logic        arm_q;
	logic        ins_q;
	logic        carry_v_q;
	slot_idx_t   carry_q;
	slot_idx_t   h_q;

	// memories
	slot_idx_t   ord_mem [2 * SLOTS];
	slot_idx_t   ord_rd_q;
	ord_addr_t   ord_ra;
	logic        ord_we;
	ord_addr_t   ord_wa;
	slot_idx_t   ord_wd;
	logic [63:0] tmr_mem [SLOTS];
	logic [63:0] tmr_rd_q;
	slot_idx_t   tmr_ra;
	logic        tmr_we;

	// result register
	logic        res_v_q;
	logic [2:0]  res_kind_q;
	logic [3:0]  res_handle_q;
	logic        res_has_q;
	logic [31:0] res_value_q;
	logic        res_last_q;
	logic        res_fire;

	logic        accept;
	slot_idx_t   slot_ix;
	logic        in_rng;
	logic        free_found;
	slot_idx_t   free_ix;
	logic [31:0] t_start;
	logic [31:0] t_delay;
	logic [31:0] t_diff;
	logic [32:0] t_left;
	logic        ahead;
	logic        expired;
	logic        e_keep;
	logic        ins_here;
	logic [SLOTS-1:0] queued_vec;

	assign accept  = start && (state_q == S_IDLE);
	assign busy    = (state_q != S_IDLE);
	assign slot_ix = slot_idx_t'(slot_q);
	assign in_rng  = ({28'd0, slot_q} < 32'(SLOTS));

	// timer arithmetic on the registered timer read
	assign t_start = tmr_rd_q[63:32];
	assign t_delay = tmr_rd_q[31:0];
	assign t_diff  = now_q - t_start;
	assign t_left  = {1'b0, t_delay} - {1'b0, t_diff};
	assign ahead   = $signed(t_left) < $signed({1'b0, ival_q});
	assign expired = (t_diff >= t_delay);

	// find the lowest free slot
	always_comb begin
		free_found = 1'b0;
		free_ix    = '0;
		for (int i = SLOTS - 1; i >= 0; i--) begin
			if (status_q[i] == ST_FREE) begin
				free_found = 1'b1;
				free_ix    = slot_idx_t'(i);
			end
		end
	end

	always_comb begin
		for (int i = 0; i < SLOTS; i++)
			queued_vec[i] = (status_q[i] == ST_QUEUED);
	end

	function automatic slot_idx_t tgt_sel();
		return (cmd_q == CMD_ADD) ? free_ix : slot_ix;
	endfunction

	// read addresses
	assign ord_ra = (state_q == S_PRUN) ? ord_addr(bank_q, ring_pos(head_q, r_q))
	                                    : ord_addr(bank_q, head_q);
	assign tmr_ra = (state_q == S_SETUP) ? slot_ix : ord_rd_q;
	assign tmr_we = (state_q == S_SETUP) &&
	                (((cmd_q == CMD_ADD) && free_found) || ((cmd_q == CMD_UPDATE) && in_rng));

	// rebuild writes into the other bank, one per cycle, insert held by a carry
	assign e_keep   = v_s2 && (e_s2 != tgt_q);
	assign ins_here = arm_q && !ins_q && !ahead;

	always_comb begin
		ord_we = 1'b0;
		ord_wa = ord_addr(!bank_q, slot_idx_t'(w_q));
		ord_wd = e_s2;
		if (state_q == S_PRUN && e_keep) begin
			ord_we = 1'b1;
			ord_wd = ins_here ? tgt_q : (carry_v_q ? carry_q : e_s2);
		end else if (state_q == S_PFIN) begin
			ord_we = carry_v_q || (arm_q && !ins_q);
			ord_wd = carry_v_q ? carry_q : tgt_q;
		end
	end

	// raise the result strobe for the cycle after these states
	always_comb begin
		res_fire = 1'b0;
		unique case (state_q)
			S_SETUP: res_fire = (cmd_q == CMD_ADD) || ((cmd_q == CMD_UPDATE) && in_rng) ||
				((cmd_q == CMD_QUERY) && !(in_rng && status_q[slot_ix] == ST_QUEUED));
			S_TRD:   res_fire = (cnt_q == '0);
			S_TEV, S_QEV: res_fire = 1'b1;
			default: ;
		endcase
	end

	// order memory
	always_ff @(posedge clk) begin
		if (ord_we)
			ord_mem[ord_wa] <= ord_wd;
		ord_rd_q <= ord_mem[ord_ra];
	end

	// timer memory: start in the upper half, delay in the lower half
	always_ff @(posedge clk) begin
		if (tmr_we)
			tmr_mem[tgt_sel()] <= {now_q, ival_q};
		tmr_rd_q <= tmr_mem[tmr_ra];
	end

	// request fields and walk payload
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q   <= command;
			slot_q  <= slot;
			ival_q  <= delay_ms;
			ar_in_q <= autorelease;
			now_q   <= now_ms;
		end
		e_s2 <= ord_rd_q;
		if (state_q == S_TTM)
			h_q <= ord_rd_q;
		if (state_q == S_SETUP)
			tgt_q <= tgt_sel();
		if (state_q == S_PRUN && e_keep && (ins_here || carry_v_q))
			carry_q <= e_s2;
		if (state_q == S_SETUP && cmd_q == CMD_ADD && free_found)
			autorel_q[free_ix] <= ar_in_q;
		if (state_q == S_SETUP && cmd_q == CMD_UPDATE && in_rng &&
		    status_q[slot_ix] == ST_FREE)
			autorel_q[slot_ix] <= 1'b0;
		unique case (state_q)
			S_SETUP: begin
				res_last_q <= 1'b1;
				unique case (cmd_q)
					CMD_ADD: begin
						res_kind_q   <= free_found ? KIND_HANDLE : KIND_FULL;
						res_has_q    <= free_found && !ar_in_q;
						res_handle_q <= (free_found && !ar_in_q) ? 4'(free_ix) : 4'd0;
						res_value_q  <= '0;
					end
					CMD_QUERY: begin
						res_kind_q   <= KIND_PENDING;
						res_has_q    <= 1'b1;
						res_handle_q <= slot_q;
						res_value_q  <= '1;
					end
					default: begin
						res_kind_q   <= KIND_HANDLE;
						res_has_q    <= 1'b1;
						res_handle_q <= slot_q;
						res_value_q  <= '0;
					end
				endcase
			end
			S_TRD: begin
				res_kind_q   <= KIND_NEXT;
				res_handle_q <= '0;
				res_has_q    <= 1'b0;
				res_value_q  <= idle_q;
				res_last_q   <= 1'b1;
			end
			S_TEV: begin
				res_kind_q   <= expired ? KIND_FIRED : KIND_NEXT;
				res_handle_q <= expired ? 4'(h_q) : 4'd0;
				res_has_q    <= expired;
				res_value_q  <= expired ? 32'd0 : t_left[31:0];
				res_last_q   <= !expired;
			end
			S_QEV: begin
				res_kind_q   <= KIND_PENDING;
				res_handle_q <= slot_q;
				res_has_q    <= 1'b1;
				res_value_q  <= (!t_left[32] && t_left != '0) ? t_left[31:0] : 32'd1;
				res_last_q   <= 1'b1;
			end
			default: ;
		endcase
	end

	// control: sequencer, queue bookkeeping, slot status
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			idle_q    <= IDLE_INTERVAL_RST;
			cnt_q     <= '0;
			head_q    <= '0;
			bank_q    <= 1'b0;
			r_q       <= '0;
			w_q       <= '0;
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
			arm_q     <= 1'b0;
			ins_q     <= 1'b0;
			carry_v_q <= 1'b0;
			res_v_q   <= 1'b0;
			for (int i = 0; i < SLOTS; i++)
				status_q[i] <= ST_FREE;
		end else begin
			res_v_q <= res_fire;
			if (idle_interval_we)
				idle_q <= idle_interval_wdata;
			unique case (state_q)
				S_IDLE: begin
					if (start)
						state_q <= S_SETUP;
				end
				S_SETUP: begin
					r_q       <= '0;
					w_q       <= '0;
					v_s1      <= 1'b0;
					v_s2      <= 1'b0;
					ins_q     <= 1'b0;
					carry_v_q <= 1'b0;
					arm_q     <= (cmd_q != CMD_CANCEL);
					unique case (cmd_q)
						CMD_ADD: begin
							if (free_found) begin
								status_q[free_ix] <= ST_QUEUED;
								state_q <= S_PRUN;
							end else begin
								state_q <= S_IDLE;
							end
						end
						CMD_UPDATE: begin
							if (in_rng) begin
								status_q[slot_ix] <= ST_QUEUED;
								state_q <= S_PRUN;
							end else begin
								state_q <= S_IDLE;
							end
						end
						CMD_CANCEL: begin
							if (in_rng) begin
								status_q[slot_ix] <= ST_FREE;
								state_q <= (status_q[slot_ix] == ST_QUEUED) ? S_PRUN : S_IDLE;
							end else begin
								state_q <= S_IDLE;
							end
						end
						CMD_TICK: state_q <= S_TRD;
						CMD_QUERY: state_q <= (in_rng && status_q[slot_ix] == ST_QUEUED) ?
						                      S_QEV : S_IDLE;
						default: state_q <= S_IDLE;
					endcase
				end
				S_PRUN: begin
					v_s1 <= (r_q < cnt_q);
					v_s2 <= v_s1;
					if (r_q < cnt_q)
						r_q <= r_q + 1'b1;
					if (e_keep) begin
						w_q <= w_q + 1'b1;
						if (ins_here) begin
							ins_q     <= 1'b1;
							carry_v_q <= 1'b1;
						end
					end
					if (r_q >= cnt_q && !v_s1 && !v_s2)
						state_q <= S_PFIN;
				end
				S_PFIN: begin
					cnt_q     <= w_q + slot_cnt_t'(ord_we);
					bank_q    <= !bank_q;
					head_q    <= '0;
					carry_v_q <= 1'b0;
					state_q   <= S_IDLE;
				end
				S_TRD: state_q <= (cnt_q == '0) ? S_IDLE : S_TTM;
				S_TTM: state_q <= S_TEV;
				S_TEV: begin
					if (expired) begin
						head_q <= ring_pos(head_q, slot_cnt_t'(1));
						cnt_q  <= cnt_q - 1'b1;
						status_q[h_q] <= autorel_q[h_q] ? ST_FREE : ST_IDLE;
						state_q <= S_TRD;
					end else begin
						state_q <= S_IDLE;
					end
				end
				S_QEV: state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign result_valid = res_v_q;
	assign kind         = res_kind_q;
	assign handle       = res_handle_q;
	assign has_handle   = res_has_q;
	assign value        = res_value_q;
	assign last         = res_last_q;

`ifndef SYNTHESIS
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= slot_cnt_t'(SLOTS))
		else $error("queue count beyond slot count");
	a_cnt_matches_status: assert property (@(posedge clk) disable iff (!arst_n)
		!busy |-> ($countones(queued_vec) == 32'(cnt_q)))
		else $error("queue count disagrees with queued slots");
	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && last) |=> !result_valid)
		else $error("result after final result of a request");
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> busy)
		else $error("accepted request did not raise busy");
	a_result_from_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(busy))
		else $error("result without a request in progress");
`endif

endmodule
